/* hw/rtl/mp5ml_pkg.sv */
package mp5ml_pkg;

    localparam int DW  = 32;        // Q16.16 data word
    localparam int DLW = DW + 1;    // first differences
    localparam int CW  = DW + 2;    // curvatures and minmod4 results
    localparam int AW  = DW + 4;    // alpha times a first difference
    localparam int TW  = DW + 5;    // minmod4 arguments (4*a - b)
    localparam int VW  = DW + 5;    // candidate interface values
    localparam int NW  = DW + 6;    // numerator of the vlc correction
    localparam int MW  = DW + 5;    // magnitude into the divide-by-3
    localparam int WW  = DW + 7;    // minmod working width

    localparam int ALW = 4;
    localparam logic [ALW-1:0] ALPHA_RST = 4'd4;
    localparam logic [ALW-1:0] ALPHA_MIN = 4'd2;
    localparam logic [ALW-1:0] ALPHA_MAX = 4'd8;

    // floor(x / 3) = (x * DIV_RECIP) >> DIV_SHIFT, exact for x < 2**(DIV_SHIFT - 1)
    localparam int DIV_LO    = (MW + 1) / 2;
    localparam int DIV_SHIFT = MW + 1;
    localparam logic [MW-1:0] DIV_RECIP = MW'(((65'd1 << DIV_SHIFT) + 65'd2) / 65'd3);
    localparam int PLW = DIV_LO + MW;
    localparam int PHW = MW - DIV_LO + MW;
    localparam int PW  = 2 * MW;
    localparam int QW  = PW - DIV_SHIFT;

    typedef logic signed [DW-1:0] data_t;
    typedef logic signed [WW-1:0] wide_t;

    localparam data_t DATA_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        data_t v_minus2;
        data_t v_minus1;
        data_t v_center;
        data_t v_plus1;
        data_t v_plus2;
        data_t unlimited_value;
        logic  reversed;
    } stencil_t;

    typedef struct packed {
        data_t limited_value;
        logic  was_active;
    } result_t;

    // front end -> bound section
    typedef struct packed {
        logic signed [VW-1:0]  vmp;
        logic signed [VW-1:0]  vul;
        logic signed [CW-1:0]  d4p;
        logic signed [CW-1:0]  d4m;
        logic signed [DLW-1:0] dl;
        data_t                 vj;
        data_t                 vjp1;
        data_t                 u;
    } front_t;

    // bound section -> clamp
    typedef struct packed {
        logic                 active;
        logic signed [VW-1:0] vmd;
        logic signed [VW-1:0] q;
        data_t                lo1;
        data_t                hi1;
        logic signed [VW-1:0] lo2;
        logic signed [VW-1:0] hi2;
        data_t                vj;
        data_t                u;
    } bound_t;

    function automatic wide_t wmin(input wide_t x, input wide_t y);
        return (x < y) ? x : y;
    endfunction

    function automatic wide_t wmax(input wide_t x, input wide_t y);
        return (x > y) ? x : y;
    endfunction

    // both negative: signed max is the smaller magnitude
    function automatic wide_t mm2(input wide_t x, input wide_t y);
        wide_t r;
        r = '0;
        if (x > 0 && y > 0)
        begin
            r = wmin(x, y);
        end
        else if (x < 0 && y < 0)
        begin
            r = wmax(x, y);
        end
        return r;
    endfunction

    function automatic wide_t mm4(input wide_t a, input wide_t b, input wide_t c,
                                  input wide_t d);
        wide_t r;
        r = '0;
        if (a > 0 && b > 0 && c > 0 && d > 0)
        begin
            r = wmin(wmin(a, b), wmin(c, d));
        end
        else if (a < 0 && b < 0 && c < 0 && d < 0)
        begin
            r = wmax(wmax(a, b), wmax(c, d));
        end
        return r;
    endfunction

endpackage

/* hw/rtl/mp5ml_front.sv */
module mp5ml_front
    import mp5ml_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [ALW-1:0] alpha,
    input  logic           up_valid,
    input  stencil_t       up_data,
    output logic           up_ready,
    output logic           dn_valid,
    output front_t         dn_data,
    input  logic           dn_ready
);

    localparam int NS = 3;

    typedef struct packed {
        logic signed [DLW-1:0] dl;
        logic signed [DLW-1:0] dr;
        logic signed [CW-1:0]  dm1;
        logic signed [CW-1:0]  d0;
        logic signed [CW-1:0]  dp1;
        data_t                 vj;
        data_t                 vjp1;
        data_t                 u;
    } f1_t;

    typedef struct packed {
        logic signed [AW-1:0]  adl;
        logic signed [TW-1:0]  t1;
        logic signed [TW-1:0]  t2;
        logic signed [TW-1:0]  t3;
        logic signed [TW-1:0]  t4;
        logic signed [DLW-1:0] dl;
        logic signed [DLW-1:0] dr;
        logic signed [CW-1:0]  dm1;
        logic signed [CW-1:0]  d0;
        logic signed [CW-1:0]  dp1;
        data_t                 vj;
        data_t                 vjp1;
        data_t                 u;
    } f2_t;

    logic [NS-1:0] vld_reg;
    logic [NS:0]   en;
    f1_t           f1_next, f1_reg;
    f2_t           f2_next, f2_reg;
    front_t        f3_next, f3_reg;

    always_comb
    begin
        en[NS] = dn_ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    // stage 1: orient the stencil, first differences and curvatures
    always_comb
    begin
        data_t c0, c1, c2, c3, c4;
        if (up_data.reversed)
        begin
            c0 = up_data.v_plus2;
            c1 = up_data.v_plus1;
            c2 = up_data.v_center;
            c3 = up_data.v_minus1;
            c4 = up_data.v_minus2;
        end
        else
        begin
            c0 = up_data.v_minus2;
            c1 = up_data.v_minus1;
            c2 = up_data.v_center;
            c3 = up_data.v_plus1;
            c4 = up_data.v_plus2;
        end
        f1_next.dl   = DLW'(c2) - DLW'(c1);
        f1_next.dr   = DLW'(c3) - DLW'(c2);
        f1_next.dm1  = CW'(c0) + CW'(c2) - (CW'(c1) <<< 1);
        f1_next.d0   = CW'(c1) + CW'(c3) - (CW'(c2) <<< 1);
        f1_next.dp1  = CW'(c2) + CW'(c4) - (CW'(c3) <<< 1);
        f1_next.vj   = c2;
        f1_next.vjp1 = c3;
        f1_next.u    = up_data.unlimited_value;
    end

    // stage 2: slope product and minmod4 arguments
    always_comb
    begin
        logic signed [ALW:0] a_s;
        a_s = signed'({1'b0, alpha});
        f2_next.adl  = AW'(f1_reg.dl) * AW'(a_s);
        f2_next.t1   = (TW'(f1_reg.d0) <<< 2) - TW'(f1_reg.dp1);
        f2_next.t2   = (TW'(f1_reg.dp1) <<< 2) - TW'(f1_reg.d0);
        f2_next.t3   = (TW'(f1_reg.dm1) <<< 2) - TW'(f1_reg.d0);
        f2_next.t4   = (TW'(f1_reg.d0) <<< 2) - TW'(f1_reg.dm1);
        f2_next.dl   = f1_reg.dl;
        f2_next.dr   = f1_reg.dr;
        f2_next.dm1  = f1_reg.dm1;
        f2_next.d0   = f1_reg.d0;
        f2_next.dp1  = f1_reg.dp1;
        f2_next.vj   = f1_reg.vj;
        f2_next.vjp1 = f1_reg.vjp1;
        f2_next.u    = f1_reg.u;
    end

    // stage 3: MP bound, upper limit, curvature minmods
    always_comb
    begin
        wide_t mp;
        mp = mm2(WW'(f2_reg.dr), WW'(f2_reg.adl));
        f3_next.vmp  = VW'(f2_reg.vj) + VW'(mp);
        f3_next.vul  = VW'(f2_reg.vj) + VW'(f2_reg.adl);
        f3_next.d4p  = CW'(mm4(WW'(f2_reg.t1), WW'(f2_reg.t2),
                               WW'(f2_reg.d0), WW'(f2_reg.dp1)));
        f3_next.d4m  = CW'(mm4(WW'(f2_reg.t3), WW'(f2_reg.t4),
                               WW'(f2_reg.dm1), WW'(f2_reg.d0)));
        f3_next.dl   = f2_reg.dl;
        f3_next.vj   = f2_reg.vj;
        f3_next.vjp1 = f2_reg.vjp1;
        f3_next.u    = f2_reg.u;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= up_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            f1_reg <= f1_next;
        end
        if (en[1])
        begin
            f2_reg <= f2_next;
        end
        if (en[2])
        begin
            f3_reg <= f3_next;
        end
    end

    assign up_ready = en[0];
    assign dn_valid = vld_reg[NS-1];
    assign dn_data  = f3_reg;

endmodule

/* hw/rtl/mp5ml_bound.sv */
module mp5ml_bound
    import mp5ml_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   up_valid,
    input  front_t up_data,
    output logic   up_ready,
    output logic   dn_valid,
    output bound_t dn_data,
    input  logic   dn_ready
);

    localparam int NS = 4;

    typedef struct packed {
        logic                 active;
        logic signed [VW-1:0] vmd;
        logic signed [MW-1:0] m;
        data_t                lo1;
        data_t                hi1;
        logic signed [VW-1:0] lo2;
        logic signed [VW-1:0] hi2;
        data_t                vj;
        data_t                u;
    } b1_t;

    typedef struct packed {
        logic                 active;
        logic                 neg;
        logic [MW-1:0]        mag;
        logic signed [VW-1:0] vmd;
        data_t                lo1;
        data_t                hi1;
        logic signed [VW-1:0] lo2;
        logic signed [VW-1:0] hi2;
        data_t                vj;
        data_t                u;
    } b2_t;

    typedef struct packed {
        logic                 active;
        logic                 neg;
        logic [PLW-1:0]       pl;
        logic [PHW-1:0]       ph;
        logic signed [VW-1:0] vmd;
        data_t                lo1;
        data_t                hi1;
        logic signed [VW-1:0] lo2;
        logic signed [VW-1:0] hi2;
        data_t                vj;
        data_t                u;
    } b3_t;

    logic [NS-1:0] vld_reg;
    logic [NS:0]   en;
    b1_t           b1_next, b1_reg;
    b2_t           b2_next, b2_reg;
    b3_t           b3_next, b3_reg;
    bound_t        b4_next, b4_reg;

    always_comb
    begin
        en[NS] = dn_ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    // stage 1: sign test, median value, vlc numerator halved
    always_comb
    begin
        wide_t                du, dq, sum;
        logic signed [NW-1:0] n;
        logic signed [VW-1:0] vj_w;
        du   = WW'(up_data.u) - WW'(up_data.vj);
        dq   = WW'(up_data.u) - WW'(up_data.vmp);
        sum  = WW'(up_data.vj) + WW'(up_data.vjp1) - WW'(up_data.d4p) + WW'(1);
        n    = (NW'(up_data.dl) <<< 1) + NW'(up_data.dl) + (NW'(up_data.d4m) <<< 3)
               + NW'(3);
        vj_w = VW'(up_data.vj);
        b1_next.active = (du > 0 && dq > 0) || (du < 0 && dq < 0);
        b1_next.vmd    = VW'(sum >>> 1);
        // floor(n / 6) = floor(floor(n / 2) / 3)
        b1_next.m      = MW'(n >>> 1);
        b1_next.lo1    = (up_data.vj < up_data.vjp1) ? up_data.vj : up_data.vjp1;
        b1_next.hi1    = (up_data.vj > up_data.vjp1) ? up_data.vj : up_data.vjp1;
        b1_next.lo2    = (vj_w < up_data.vul) ? vj_w : up_data.vul;
        b1_next.hi2    = (vj_w > up_data.vul) ? vj_w : up_data.vul;
        b1_next.vj     = up_data.vj;
        b1_next.u      = up_data.u;
    end

    // stage 2: floor on negatives via -ceil(|m| / 3) = -floor((|m| + 2) / 3)
    always_comb
    begin
        b2_next.active = b1_reg.active;
        b2_next.neg    = b1_reg.m[MW-1];
        b2_next.mag    = b1_reg.m[MW-1] ? unsigned'(MW'(2) - b1_reg.m)
                                        : unsigned'(b1_reg.m);
        b2_next.vmd    = b1_reg.vmd;
        b2_next.lo1    = b1_reg.lo1;
        b2_next.hi1    = b1_reg.hi1;
        b2_next.lo2    = b1_reg.lo2;
        b2_next.hi2    = b1_reg.hi2;
        b2_next.vj     = b1_reg.vj;
        b2_next.u      = b1_reg.u;
    end

    // stage 3: reciprocal multiply, two partial products
    always_comb
    begin
        b3_next.active = b2_reg.active;
        b3_next.neg    = b2_reg.neg;
        b3_next.pl     = PLW'(b2_reg.mag[DIV_LO-1:0]) * PLW'(DIV_RECIP);
        b3_next.ph     = PHW'(b2_reg.mag[MW-1:DIV_LO]) * PHW'(DIV_RECIP);
        b3_next.vmd    = b2_reg.vmd;
        b3_next.lo1    = b2_reg.lo1;
        b3_next.hi1    = b2_reg.hi1;
        b3_next.lo2    = b2_reg.lo2;
        b3_next.hi2    = b2_reg.hi2;
        b3_next.vj     = b2_reg.vj;
        b3_next.u      = b2_reg.u;
    end

    // stage 4: combine partials, take quotient, restore sign
    always_comb
    begin
        logic [PW-1:0]        prod;
        logic signed [VW-1:0] qv;
        prod = (PW'(b3_reg.ph) << DIV_LO) + PW'(b3_reg.pl);
        qv   = signed'(VW'(prod[PW-1:DIV_SHIFT]));
        b4_next.active = b3_reg.active;
        b4_next.vmd    = b3_reg.vmd;
        b4_next.q      = b3_reg.neg ? -qv : qv;
        b4_next.lo1    = b3_reg.lo1;
        b4_next.hi1    = b3_reg.hi1;
        b4_next.lo2    = b3_reg.lo2;
        b4_next.hi2    = b3_reg.hi2;
        b4_next.vj     = b3_reg.vj;
        b4_next.u      = b3_reg.u;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= up_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            b1_reg <= b1_next;
        end
        if (en[1])
        begin
            b2_reg <= b2_next;
        end
        if (en[2])
        begin
            b3_reg <= b3_next;
        end
        if (en[3])
        begin
            b4_reg <= b4_next;
        end
    end

    assign up_ready = en[0];
    assign dn_valid = vld_reg[NS-1];
    assign dn_data  = b4_reg;

endmodule

/* hw/rtl/mp5ml_clamp.sv */
module mp5ml_clamp
    import mp5ml_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    up_valid,
    input  bound_t  up_data,
    output logic    up_ready,
    output logic    dn_valid,
    output result_t dn_data,
    input  logic    dn_ready
);

    localparam int NS = 2;

    typedef struct packed {
        logic                 active;
        logic signed [VW-1:0] vmin;
        logic signed [VW-1:0] vmax;
        data_t                u;
    } c1_t;

    logic [NS-1:0] vld_reg;
    logic [NS:0]   en;
    c1_t           c1_next, c1_reg;
    result_t       c2_next, c2_reg;

    always_comb
    begin
        en[NS] = dn_ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    // stage 1: curvature-corrected value and the bound interval
    always_comb
    begin
        wide_t vlc;
        vlc = WW'(up_data.vj) + WW'(up_data.q);
        c1_next.active = up_data.active;
        c1_next.vmin   = VW'(wmax(wmin(WW'(up_data.lo1), WW'(up_data.vmd)),
                                  wmin(WW'(up_data.lo2), vlc)));
        c1_next.vmax   = VW'(wmin(wmax(WW'(up_data.hi1), WW'(up_data.vmd)),
                                  wmax(WW'(up_data.hi2), vlc)));
        c1_next.u      = up_data.u;
    end

    // stage 2: median clamp, saturate; inactive items pass through
    always_comb
    begin
        wide_t r;
        data_t sat;
        r = WW'(c1_reg.u) + mm2(WW'(c1_reg.vmin) - WW'(c1_reg.u),
                                WW'(c1_reg.vmax) - WW'(c1_reg.u));
        if (r > WW'(DATA_MAX))
        begin
            sat = DATA_MAX;
        end
        else if (r < WW'(DATA_MIN))
        begin
            sat = DATA_MIN;
        end
        else
        begin
            sat = DW'(r);
        end
        c2_next.limited_value = c1_reg.active ? sat : c1_reg.u;
        c2_next.was_active    = c1_reg.active;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= up_valid;
            end
            if (en[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            c1_reg <= c1_next;
        end
        if (en[1])
        begin
            c2_reg <= c2_next;
        end
    end

    assign up_ready = en[0];
    assign dn_valid = vld_reg[NS-1];
    assign dn_data  = c2_reg;

endmodule

/* hw/rtl/mp5_monotonicity_limiter_core.sv */
// Pipeline: 9 register stages from the stencil input to the result.
// Throughput: one item per cycle while result_stall is low; up to 9 items in flight.
// Empty stages take new items while a result waits, so input stalls only when full.
// The bound section spreads the divide-by-3 over its magnitude, multiply and combine stages.
// Reset (rst_n, async low) clears all stage valid bits and sets alpha to 4.
module mp5_monotonicity_limiter_core
    import mp5ml_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           alpha_valid,
    output logic           alpha_ready,
    input  logic [ALW-1:0] alpha_data,
    input  logic           stencil_valid,
    output logic           stencil_stall,
    input  stencil_t       stencil,
    output logic           result_valid,
    input  logic           result_stall,
    output result_t        result
);

    logic [ALW-1:0] alpha_reg, alpha_next;
    logic           front_ready;
    logic           front_valid;
    front_t         front_data;
    logic           bound_ready;
    logic           bound_valid;
    bound_t         bound_data;
    logic           clamp_ready;

    // clamp into [2, 8] at write time
    always_comb
    begin
        if (alpha_data < ALPHA_MIN)
        begin
            alpha_next = ALPHA_MIN;
        end
        else if (alpha_data > ALPHA_MAX)
        begin
            alpha_next = ALPHA_MAX;
        end
        else
        begin
            alpha_next = alpha_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RST;
        end
        else if (alpha_valid && alpha_ready)
        begin
            alpha_reg <= alpha_next;
        end
    end

    assign alpha_ready = 1'b1;

    mp5ml_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .alpha    (alpha_reg),
        .up_valid (stencil_valid),
        .up_data  (stencil),
        .up_ready (front_ready),
        .dn_valid (front_valid),
        .dn_data  (front_data),
        .dn_ready (bound_ready)
    );

    mp5ml_bound u_bound (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (front_valid),
        .up_data  (front_data),
        .up_ready (bound_ready),
        .dn_valid (bound_valid),
        .dn_data  (bound_data),
        .dn_ready (clamp_ready)
    );

    mp5ml_clamp u_clamp (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (bound_valid),
        .up_data  (bound_data),
        .up_ready (clamp_ready),
        .dn_valid (result_valid),
        .dn_data  (result),
        .dn_ready (!result_stall)
    );

    assign stencil_stall = !front_ready;

    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        alpha_reg >= ALPHA_MIN && alpha_reg <= ALPHA_MAX)
        else $error("alpha register outside clamp range");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        stencil_stall |-> result_valid)
        else $error("input stalled while output stage is empty");

    a_alpha_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(alpha_valid) |-> $stable(alpha_reg))
        else $error("alpha changed without a config transfer");

endmodule
